// File: rtl/watermark_jitter_byte_fifo_top_macros.svh
// Assertion macros for the jitter buffer byte FIFO.
// Used by watermark_jitter_byte_fifo_top; relies on clk and arst_n in scope.
`ifndef WATERMARK_JITTER_BYTE_FIFO_TOP_MACROS_SVH
`define WATERMARK_JITTER_BYTE_FIFO_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define WJBF_AST_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wjbf: same-cycle check failed");
// next-cycle implication
`define WJBF_AST_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wjbf: next-cycle check failed");
`else
`define WJBF_AST_IMP(label, ante, cons)
`define WJBF_AST_NXT(label, ante, cons)
`endif
`endif

// File: rtl/wjbf_pkg.sv
// Shared types and constants of the jitter buffer byte FIFO.
// No dependencies; used by the top level and the testbench.
package wjbf_pkg;

	localparam int DEPTH_DEFAULT    = 4096;
	localparam int MAX_PEEK_DEFAULT = 64;

	// operation codes
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_PEEK   = 3'd1;
	localparam logic [2:0] OP_DROP   = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_RECENT = 3'd4;

	// register indexes
	localparam int         CFG_IDX_W     = 2;
	localparam logic [1:0] REG_CAPACITY  = 2'd0;
	localparam logic [1:0] REG_LOW_WMARK = 2'd1;
	localparam logic [1:0] REG_HIGH_WMARK = 2'd2;

	localparam logic [12:0] CAPACITY_RST   = 13'd4096;
	localparam logic [12:0] LOW_WMARK_RST  = 13'd1024;
	localparam logic [12:0] HIGH_WMARK_RST = 13'd3072;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  data_byte;
		logic [12:0] packet_length;
		logic [31:0] sequence_number;
		logic [6:0]  peek_length;
		logic [12:0] drop_length;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        ok;
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        last;
		logic [12:0] level;
		logic        active;
		logic [12:0] recent_low;
		logic [12:0] recent_high;
		logic [31:0] expected_sequence;
		logic [31:0] total_inserted;
	} result_t;

endpackage

// File: rtl/wjbf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module wjbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/watermark_jitter_byte_fifo_top.sv
// Jitter buffer byte FIFO with fill watermarks: top level.
// Depends on wjbf_pkg, wjbf_ram and watermark_jitter_byte_fifo_top_macros.svh.
//
// Byte FIFO for a jitter buffer. Packets come in one byte per insert request;
// the first byte decides whether the whole packet is taken (nonzero length,
// fits the free space, sequence number zero or above the last accepted one),
// and a taken packet becomes visible at once on its final byte. Reaching the
// high watermark makes the block active; a drop down to the low watermark or
// below returns it to filling. Insert, drop, clear and recent-reset requests
// may follow back to back; each gives one result, held in an output
// register. The next request is taken in the cycle that result leaves, so
// a stalled result also stalls the request side. A peek of n bytes streams
// n results out of the byte store, one per cycle while the output does not
// stall: the store has a single read port with a registered read, so reads
// are issued one per cycle while no held byte is stalled, and the last byte
// must leave the read register before the next request is taken. An empty
// peek gives a single result. The byte store is not cleared after reset;
// only bytes inside the fill level are ever read. Config writes are taken
// at any time (cfg_ready is tied high) but are meant for idle time.
`include "watermark_jitter_byte_fifo_top_macros.svh"

module watermark_jitter_byte_fifo_top #(
	parameter int DEPTH    = wjbf_pkg::DEPTH_DEFAULT,
	parameter int MAX_PEEK = wjbf_pkg::MAX_PEEK_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  wjbf_pkg::item_t                item,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output wjbf_pkg::result_t              result,
	// config write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wjbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [12:0]                    cfg_data
);

	localparam int PW = $clog2(DEPTH);                  // store address width
	localparam int SW = ((PW > 14) ? PW : 14) + 1;      // address sum width
	localparam int RW = $clog2(MAX_PEEK + 1);           // peek count width

	// config registers
	logic [12:0] capacity_q, low_wm_q, high_wm_q;

	// block state
	logic [PW-1:0] head_q;
	logic [12:0]   level_q;
	logic          active_q;
	logic [12:0]   lmin_q, lmax_q;
	logic [31:0]   last_seq_q;
	logic [31:0]   ins_cnt_q;
	logic [12:0]   seen_q;
	logic          taken_q;

	// peek sequencer
	logic [RW-1:0] rem_q;       // reads still to issue
	logic [PW-1:0] rd_addr_q;
	logic          pend_q;      // RAM read register holds an unsent byte
	logic          pend_last_q;

	// output register
	logic              out_v_q;
	wjbf_pkg::result_t out_q;

	logic [PW-1:0] n_head;
	logic [12:0]   n_level, n_lmin, n_lmax, n_seen;
	logic          n_active, n_taken;
	logic [31:0]   n_last_seq, n_ins_cnt;

	logic          accept, busy, out_free, move, issue, load_item;
	logic          wr_en, res_ok;
	logic [PW-1:0] wr_addr;
	logic [7:0]    rd_data;
	logic [12:0]   cap_eff, free_sp;
	logic [RW-1:0] peek_n, peek_lim;
	logic          first, take_new, tk, done;
	logic [13:0]   count;
	logic [14:0]   fill_sum;
	logic [SW-1:0] wsum, dsum;
	logic [PW:0]   rd_inc;

	wjbf_pkg::result_t item_res, byte_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= wjbf_pkg::CAPACITY_RST;
			low_wm_q   <= wjbf_pkg::LOW_WMARK_RST;
			high_wm_q  <= wjbf_pkg::HIGH_WMARK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wjbf_pkg::REG_CAPACITY:   capacity_q <= cfg_data;
				wjbf_pkg::REG_LOW_WMARK:  low_wm_q   <= cfg_data;
				wjbf_pkg::REG_HIGH_WMARK: high_wm_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign busy       = (rem_q != '0) || pend_q;
	assign out_free   = !out_v_q || !result_stall;
	assign item_stall = busy || !out_free;
	assign accept     = item_valid && !item_stall;
	assign move       = pend_q && out_free;
	assign issue      = (rem_q != '0) && (!pend_q || move);

	// capacity is bounded by the store size
	assign cap_eff = (32'(capacity_q) < 32'(DEPTH)) ? capacity_q : 13'(DEPTH);
	assign free_sp = (cap_eff > level_q) ? cap_eff - level_q : 13'd0;

	// packet decision on the first byte
	assign first    = (seen_q == 13'd0);
	assign take_new = (item.packet_length != 13'd0) && (item.packet_length <= free_sp) &&
	                  ((item.sequence_number == 32'd0) ||
	                   (item.sequence_number > last_seq_q));
	assign tk       = first ? take_new : taken_q;
	assign count    = 14'(seen_q) + 14'd1;
	assign fill_sum = 15'(level_q) + 15'(count);
	assign done     = (count >= 14'(item.packet_length)) ||
	                  (tk && (fill_sum >= 15'(cap_eff)));

	// write position, wraps once at most while a packet is taken
	assign wsum    = SW'(head_q) + SW'(level_q) + SW'(seen_q);
	assign wr_addr = (wsum >= SW'(DEPTH)) ? PW'(wsum - SW'(DEPTH)) : PW'(wsum);
	assign wr_en   = accept && (item.operation == wjbf_pkg::OP_INSERT) && tk;

	// new head after a drop
	assign dsum = SW'(head_q) + SW'(item.drop_length);

	// peek length: min(peek_length, MAX_PEEK, level)
	assign peek_lim = (32'(item.peek_length) > 32'(MAX_PEEK)) ? RW'(MAX_PEEK)
	                                                          : RW'(item.peek_length);
	assign peek_n   = (13'(peek_lim) > level_q) ? RW'(level_q) : peek_lim;

	assign rd_inc = {1'b0, rd_addr_q} + {{PW{1'b0}}, 1'b1};

	always_comb begin
		n_head     = head_q;
		n_level    = level_q;
		n_active   = active_q;
		n_lmin     = lmin_q;
		n_lmax     = lmax_q;
		n_last_seq = last_seq_q;
		n_ins_cnt  = ins_cnt_q;
		n_seen     = 13'd0;
		n_taken    = 1'b0;
		res_ok     = 1'b0;
		load_item  = accept;
		unique case (item.operation)
			wjbf_pkg::OP_INSERT: begin
				res_ok = tk;
				if (first && take_new) begin
					n_last_seq = item.sequence_number;
				end
				if (done) begin
					if (tk) begin
						n_level   = fill_sum[12:0];
						n_ins_cnt = ins_cnt_q + 32'(count);
						if (fill_sum[12:0] < lmin_q) begin
							n_lmin = fill_sum[12:0];
						end
						if (fill_sum[12:0] > lmax_q) begin
							n_lmax = fill_sum[12:0];
						end
						if (fill_sum[12:0] >= high_wm_q) begin
							n_active = 1'b1;
						end
					end
				end else begin
					n_seen  = count[12:0];
					n_taken = tk;
				end
			end
			wjbf_pkg::OP_PEEK: begin
				if (peek_n != '0) begin
					load_item = 1'b0;
				end
			end
			wjbf_pkg::OP_DROP: begin
				if (item.drop_length <= level_q) begin
					n_head  = (dsum >= SW'(DEPTH)) ? PW'(dsum - SW'(DEPTH)) : PW'(dsum);
					n_level = level_q - item.drop_length;
					res_ok  = 1'b1;
					if (n_level <= low_wm_q) begin
						n_active = 1'b0;
					end
				end
			end
			wjbf_pkg::OP_CLEAR: begin
				n_ins_cnt = 32'd0;
				n_lmin    = 13'd0;
				n_lmax    = 13'd0;
				n_level   = 13'd0;
				n_head    = '0;
			end
			wjbf_pkg::OP_RECENT: begin
				n_lmin = level_q;
				n_lmax = level_q;
			end
			default: ;
		endcase
	end

	// result of a single-result request, status after the update
	always_comb begin
		item_res.kind              = item.operation;
		item_res.ok                = res_ok;
		item_res.out_byte          = 8'd0;
		item_res.byte_valid        = 1'b0;
		item_res.last              = 1'b1;
		item_res.level             = n_level;
		item_res.active            = n_active;
		item_res.recent_low        = n_lmin;
		item_res.recent_high       = n_lmax;
		item_res.expected_sequence = n_last_seq + 32'd1;
		item_res.total_inserted    = n_ins_cnt;
	end

	// peeked byte; state stays put while a peek runs
	always_comb begin
		byte_res.kind              = wjbf_pkg::OP_PEEK;
		byte_res.ok                = 1'b0;
		byte_res.out_byte          = rd_data;
		byte_res.byte_valid        = 1'b1;
		byte_res.last              = pend_last_q;
		byte_res.level             = level_q;
		byte_res.active            = active_q;
		byte_res.recent_low        = lmin_q;
		byte_res.recent_high       = lmax_q;
		byte_res.expected_sequence = last_seq_q + 32'd1;
		byte_res.total_inserted    = ins_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			level_q    <= 13'd0;
			active_q   <= 1'b0;
			lmin_q     <= 13'd0;
			lmax_q     <= 13'd0;
			last_seq_q <= 32'd0;
			ins_cnt_q  <= 32'd0;
			seen_q     <= 13'd0;
			taken_q    <= 1'b0;
		end else if (accept) begin
			head_q     <= n_head;
			level_q    <= n_level;
			active_q   <= n_active;
			lmin_q     <= n_lmin;
			lmax_q     <= n_lmax;
			last_seq_q <= n_last_seq;
			ins_cnt_q  <= n_ins_cnt;
			seen_q     <= n_seen;
			taken_q    <= n_taken;
		end
	end

	// peek sequencer: one read a cycle while no held byte is stalled, read register acts as a holding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			rd_addr_q   <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (accept && (item.operation == wjbf_pkg::OP_PEEK) && (peek_n != '0)) begin
				rem_q     <= peek_n;
				rd_addr_q <= head_q;
			end else if (issue) begin
				rem_q     <= rem_q - RW'(1);
				rd_addr_q <= (rd_inc == (PW + 1)'(DEPTH)) ? '0 : rd_inc[PW-1:0];
			end
			if (issue) begin
				pend_q      <= 1'b1;
				pend_last_q <= (rem_q == RW'(1));
			end else if (move) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_item || move) begin
			out_v_q <= 1'b1;
		end else if (!result_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			out_q <= item_res;
		end else if (move) begin
			out_q <= byte_res;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	wjbf_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (item.data_byte),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	// a held byte survives a stalled output
	`WJBF_AST_NXT(a_pend_hold, pend_q && out_v_q && result_stall, pend_q && $stable(rd_data))
	// no store write while a peek reads
	`WJBF_AST_IMP(a_no_wr_in_peek, busy, !wr_en)
	// last peeked byte out means the sequencer is done
	`WJBF_AST_IMP(a_last_byte_idle, out_v_q && out_q.byte_valid && out_q.last,
		(rem_q == '0) && !pend_q)
	// level never exceeds the store
	`WJBF_AST_IMP(a_level_bound, 1'b1, 32'(level_q) <= 32'(DEPTH))

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the jitter buffer byte FIFO with fill watermarks.
// Depends on wjbf_pkg and watermark_jitter_byte_fifo_top. It predicts each result
// from its own FIFO model, drives random stalls and gaps, and reads no files.
module tb_top;

	localparam int         FIFO_DEPTH   = wjbf_pkg::DEPTH_DEFAULT;
	localparam int         PEEK_MAX     = wjbf_pkg::MAX_PEEK_DEFAULT;
	localparam int         CYCLE_LIMIT  = 2000000;
	// a peek frees the block once its last byte has left, so this only adds margin
	localparam int         SETTLE_CYC   = 8;
	// operation codes the block does not define; they must answer with ok low
	localparam logic [2:0] OP_BAD_FIRST = 3'd5;
	localparam logic [2:0] OP_BAD_LAST  = 3'd7;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_stall;
	wjbf_pkg::item_t                item;
	logic                           result_valid;
	logic                           result_stall;
	wjbf_pkg::result_t              result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [wjbf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [12:0]                    cfg_data;

	// FIFO model state, updated when a request is taken by the block
	logic [7:0]  fifo_mem [FIFO_DEPTH];
	int unsigned head_ptr    = 0;
	int unsigned level_now   = 0;
	int unsigned pkt_seen    = 0;
	logic        pkt_taken   = 1'b0;
	logic        mode_on     = 1'b0;
	int unsigned lvl_low     = 0;
	int unsigned lvl_high    = 0;
	logic [31:0] seq_last    = '0;
	logic [31:0] bytes_total = '0;

	// register copies, at their reset values
	int unsigned cap_reg   = wjbf_pkg::CAPACITY_RST;
	int unsigned low_mark  = wjbf_pkg::LOW_WMARK_RST;
	int unsigned high_mark = wjbf_pkg::HIGH_WMARK_RST;

	// results the FIFO still owes, oldest first
	wjbf_pkg::result_t answers_q [$];

	int fail_count  = 0;
	int cycle_count = 0;
	int req_count   = 0;
	bit calm        = 1'b0;	// no gaps and no stalls when set

	always #5 clk = ~clk;

	watermark_jitter_byte_fifo_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	//--------------------------------------------------------------------
	// FIFO prediction
	//--------------------------------------------------------------------

	// queue one expected result built from the current model state
	task automatic push_answer(logic [2:0] op, logic okv, logic [7:0] b, logic bv, logic lst);
		wjbf_pkg::result_t r;
		r.kind              = op;
		r.ok                = okv;
		r.out_byte          = b;
		r.byte_valid        = bv;
		r.last              = lst;
		r.level             = 13'(level_now);
		r.active            = mode_on;
		r.recent_low        = 13'(lvl_low);
		r.recent_high       = 13'(lvl_high);
		r.expected_sequence = seq_last + 32'd1;
		r.total_inserted    = bytes_total;
		answers_q.push_back(r);
	endtask

	// apply one taken request to the model and queue what it must answer
	task automatic fifo_apply(wjbf_pkg::item_t rq);
		int unsigned eff_cap;
		int unsigned room;
		int unsigned cnt;
		int unsigned n;
		logic        took;
		logic        done;
		// capacity beyond the store size acts as the store size
		eff_cap = (cap_reg > FIFO_DEPTH) ? FIFO_DEPTH : cap_reg;
		if (rq.operation == wjbf_pkg::OP_INSERT) begin
			// the first byte decides for the whole packet
			if (pkt_seen == 0) begin
				room = (eff_cap > level_now) ? eff_cap - level_now : 0;
				pkt_taken = rq.packet_length != 0 && rq.packet_length <= room &&
					(rq.sequence_number == 0 || rq.sequence_number > seq_last);
				if (pkt_taken)
					seq_last = rq.sequence_number;
			end
			took = pkt_taken;
			if (pkt_taken)
				fifo_mem[(head_ptr + level_now + pkt_seen) % FIFO_DEPTH] = rq.data_byte;
			cnt = pkt_seen + 1;
			// ends on reaching this byte's length, or when a taken packet fills up
			done = cnt >= rq.packet_length || (pkt_taken && level_now + cnt >= eff_cap);
			if (done) begin
				if (pkt_taken) begin
					level_now += cnt;
					if (level_now < lvl_low)
						lvl_low = level_now;
					if (level_now > lvl_high)
						lvl_high = level_now;
					bytes_total += cnt;
					if (level_now >= high_mark)
						mode_on = 1'b1;
				end
				pkt_seen  = 0;
				pkt_taken = 1'b0;
			end else begin
				pkt_seen = cnt;
			end
			push_answer(wjbf_pkg::OP_INSERT, took, 8'h00, 1'b0, 1'b1);
			return;
		end
		// anything but an insert drops a packet in progress
		pkt_seen  = 0;
		pkt_taken = 1'b0;
		case (rq.operation)
			wjbf_pkg::OP_PEEK: begin
				n = rq.peek_length;
				if (n > PEEK_MAX)
					n = PEEK_MAX;
				if (n > level_now)
					n = level_now;
				if (n == 0)
					push_answer(wjbf_pkg::OP_PEEK, 1'b0, 8'h00, 1'b0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						push_answer(wjbf_pkg::OP_PEEK, 1'b0,
							fifo_mem[(head_ptr + i) % FIFO_DEPTH], 1'b1, (i + 1) == n);
			end
			wjbf_pkg::OP_DROP: begin
				took = 1'b0;
				if (rq.drop_length <= level_now) begin
					head_ptr   = (head_ptr + rq.drop_length) % FIFO_DEPTH;
					level_now -= rq.drop_length;
					if (level_now <= low_mark)
						mode_on = 1'b0;
					took = 1'b1;
				end
				push_answer(wjbf_pkg::OP_DROP, took, 8'h00, 1'b0, 1'b1);
			end
			wjbf_pkg::OP_CLEAR: begin
				// mode and last sequence survive a clear
				bytes_total = '0;
				lvl_low     = 0;
				lvl_high    = 0;
				level_now   = 0;
				head_ptr    = 0;
				push_answer(wjbf_pkg::OP_CLEAR, 1'b0, 8'h00, 1'b0, 1'b1);
			end
			wjbf_pkg::OP_RECENT: begin
				lvl_low  = level_now;
				lvl_high = level_now;
				push_answer(wjbf_pkg::OP_RECENT, 1'b0, 8'h00, 1'b0, 1'b1);
			end
			default:
				push_answer(rq.operation, 1'b0, 8'h00, 1'b0, 1'b1);
		endcase
	endtask

	//--------------------------------------------------------------------
	// Request side
	//--------------------------------------------------------------------

	// Called at a rising edge. Valid stays high from one request to the next
	// unless a gap is inserted; stall is looked at on the falling edge, where
	// everything has settled, and the request is taken on the next rising edge.
	task automatic send_req(wjbf_pkg::item_t rq);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= rq;
		item_valid <= 1'b1;
		@(negedge clk);
		while (item_stall) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		fifo_apply(rq);
		req_count++;
	endtask

	// request with every field random, then the operation set
	function automatic wjbf_pkg::item_t req_of(logic [2:0] op);
		wjbf_pkg::item_t r;
		r.operation       = op;
		r.data_byte       = 8'($urandom);
		r.packet_length   = 13'($urandom_range(0, 4096));
		r.sequence_number = $urandom;
		r.peek_length     = 7'($urandom_range(0, PEEK_MAX));
		r.drop_length     = 13'($urandom_range(0, 4096));
		return r;
	endfunction

	task automatic put_byte(int unsigned plen, logic [31:0] seq, logic [7:0] b);
		wjbf_pkg::item_t r;
		r                 = req_of(wjbf_pkg::OP_INSERT);
		r.packet_length   = 13'(plen);
		r.sequence_number = seq;
		r.data_byte       = b;
		send_req(r);
	endtask

	task automatic peek_bytes(int unsigned n);
		wjbf_pkg::item_t r;
		r             = req_of(wjbf_pkg::OP_PEEK);
		r.peek_length = 7'(n);
		send_req(r);
	endtask

	task automatic drop_bytes(int unsigned n);
		wjbf_pkg::item_t r;
		r             = req_of(wjbf_pkg::OP_DROP);
		r.drop_length = 13'(n);
		send_req(r);
	endtask

	task automatic plain_op(logic [2:0] op);
		send_req(req_of(op));
	endtask

	task automatic send_packet(int unsigned plen, logic [31:0] seq);
		for (int unsigned k = 0; k < plen; k++)
			put_byte(plen, seq, 8'($urandom));
	endtask

	// let every owed result come out, then give the block time to go idle
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (answers_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	//--------------------------------------------------------------------
	// Register writes, only while the block is idle
	//--------------------------------------------------------------------

	task automatic write_reg(logic [wjbf_pkg::CFG_IDX_W-1:0] idx, logic [12:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		case (idx)
			wjbf_pkg::REG_CAPACITY:   cap_reg   = val;
			wjbf_pkg::REG_LOW_WMARK:  low_mark  = val;
			wjbf_pkg::REG_HIGH_WMARK: high_mark = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [12:0] cap, logic [12:0] lo, logic [12:0] hi);
		write_reg(wjbf_pkg::REG_CAPACITY, cap);
		write_reg(wjbf_pkg::REG_LOW_WMARK, lo);
		write_reg(wjbf_pkg::REG_HIGH_WMARK, hi);
		cfg_valid <= 1'b0;
	endtask

	//--------------------------------------------------------------------
	// Result side
	//--------------------------------------------------------------------

	// random stall bursts, with quiet stretches in between
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	task automatic cmp_field(string fname, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
		end
	endtask

	// a result is taken on the rising edge after a falling edge that shows
	// valid high and stall low; nothing moves in between
	always @(negedge clk) begin : result_check
		wjbf_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (answers_q.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected: expected none, actual %h",
					$time, result);
			end else begin
				want = answers_q.pop_front();
				cmp_field("kind", want.kind, result.kind);
				cmp_field("ok", want.ok, result.ok);
				cmp_field("out_byte", want.out_byte, result.out_byte);
				cmp_field("byte_valid", want.byte_valid, result.byte_valid);
				cmp_field("last", want.last, result.last);
				cmp_field("level", want.level, result.level);
				cmp_field("active", want.active, result.active);
				cmp_field("recent_low", want.recent_low, result.recent_low);
				cmp_field("recent_high", want.recent_high, result.recent_high);
				cmp_field("expected_sequence", want.expected_sequence,
					result.expected_sequence);
				cmp_field("total_inserted", want.total_inserted, result.total_inserted);
			end
		end
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	//--------------------------------------------------------------------
	// Tests
	//--------------------------------------------------------------------

	// reset registers: empty peek, drops, zero length, one packet read back
	task automatic test_packet_basics();
		peek_bytes(5);			// nothing held: one empty answer
		drop_bytes(0);
		drop_bytes(4096);		// longer than the level: refused
		put_byte(0, 32'd7, 8'h55);	// zero length: refused at once
		put_byte(3, 32'd7, 8'h00);
		put_byte(3, 32'd7, 8'hFF);
		put_byte(3, 32'd7, 8'hA5);
		peek_bytes(PEEK_MAX);		// clamped to the level
		drop_bytes(1);
		plain_op(wjbf_pkg::OP_RECENT);
		plain_op(wjbf_pkg::OP_CLEAR);	// sequence 7 is kept
	endtask

	// sequence ordering, wrap of the expected sequence, abandoned packets
	task automatic test_ordering_and_abandon();
		put_byte(4096, 32'hFFFF_FFFF, 8'h5A);	// fits exactly, expected wraps to 0
		put_byte(4096, 32'hFFFF_FFFF, 8'hC3);
		peek_bytes(3);				// abandons it, nothing visible
		put_byte(1, 32'h8000_0000, 8'h11);	// not above the last one
		put_byte(1, 32'd0, 8'h22);		// zero always passes the order check
		put_byte(2, 32'd9, 8'h33);
		plain_op(OP_BAD_FIRST);			// unknown codes abandon it too
		plain_op(3'(OP_BAD_FIRST + 3'd1));
		plain_op(OP_BAD_LAST);
		put_byte(1, 32'd9, 8'h44);		// 9 stayed accepted, so refused
	endtask

	// register extremes: capacity over the store size, packet cut by capacity,
	// level above capacity
	task automatic test_config_extremes();
		wait_idle();
		set_config(13'd8191, 13'd0, 13'd0);
		put_byte(1, 32'd0, 8'h3C);		// any level is at the high mark
		peek_bytes(PEEK_MAX);
		drop_bytes(2);				// down to zero: filling again
		wait_idle();
		set_config(13'd4, 13'd4096, 13'd4096);
		put_byte(4, 32'd10, 8'h01);
		put_byte(9, 32'd10, 8'h02);		// later bytes claim a longer packet,
		put_byte(9, 32'd10, 8'h03);		// it still ends on the capacity
		put_byte(9, 32'd10, 8'h04);
		wait_idle();
		set_config(13'd2, 13'd4096, 13'd4096);
		put_byte(1, 32'd0, 8'h05);		// level above capacity: no room
		peek_bytes(PEEK_MAX);
		drop_bytes(4);
	endtask

	// random mix of packets and commands, mostly well formed
	task automatic run_random(int unsigned count);
		int unsigned stop_at;
		int unsigned sel;
		int unsigned plen;
		int unsigned room;
		int unsigned eff_cap;
		int unsigned k;
		logic [31:0] seq;
		stop_at = req_count + count;
		while (req_count < stop_at) begin
			sel     = $urandom_range(0, 99);
			eff_cap = (cap_reg > FIFO_DEPTH) ? FIFO_DEPTH : cap_reg;
			room    = (eff_cap > level_now) ? eff_cap - level_now : 0;
			// new sequence: mostly just above the last, sometimes zero, stale or wild
			k = $urandom_range(0, 9);
			if (k < 6)
				seq = (seq_last > 32'hFFFF_FF00) ? 32'd0 : seq_last + $urandom_range(1, 4);
			else if (k == 6)
				seq = 32'd0;
			else if (k == 7)
				seq = seq_last - $urandom_range(0, 2);
			else
				seq = $urandom;
			if (sel < 55) begin
				if ($urandom_range(0, 4) == 0)
					plen = $urandom_range(1, 24);
				else
					plen = $urandom_range(1, (room == 0) ? 10 : ((room < 10) ? room : 10));
				send_packet(plen, seq);
			end else if (sel < 70) begin
				if ($urandom_range(0, 3) == 0 && level_now <= PEEK_MAX)
					peek_bytes(level_now);
				else
					peek_bytes($urandom_range(0, PEEK_MAX));
			end else if (sel < 82) begin
				if ($urandom_range(0, 9) == 0)
					drop_bytes($urandom_range(0, 4096));
				else
					drop_bytes($urandom_range(0, level_now + 2));
			end else if (sel < 86) begin
				plain_op(wjbf_pkg::OP_CLEAR);
			end else if (sel < 90) begin
				plain_op(wjbf_pkg::OP_RECENT);
			end else if (sel < 96) begin
				// truncated packet whose bytes disagree on the length
				plen = $urandom_range(2, 12);
				for (k = $urandom_range(1, plen - 1); k != 0; k--)
					put_byte($urandom_range(1, plen + 4), seq, 8'($urandom));
			end else if (sel < 98) begin
				plain_op(wjbf_pkg::OP_INSERT);
			end else begin
				plain_op(3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)));
			end
		end
	endtask

	task automatic test_random_traffic();
		wait_idle();
		set_config(13'd48, 13'd8, 13'd32);
		run_random(120);
		wait_idle();
		set_config(13'd16, 13'd0, 13'd16);	// high mark equal to capacity
		run_random(100);
		wait_idle();
		set_config(13'd1, 13'd0, 13'd1);	// smallest nonzero capacity
		plain_op(wjbf_pkg::OP_CLEAR);
		run_random(50);
		wait_idle();
		set_config(13'd4096, 13'd4096, 13'd0);	// full store, marks swapped
		run_random(120);
	endtask

	// closing stretch with no gaps and no stalls
	task automatic test_steady_stream();
		calm = 1'b1;
		wait_idle();
		set_config(13'd64, 13'd16, 13'd48);
		run_random(60);
	endtask

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= wjbf_pkg::REG_CAPACITY;
		cfg_data   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_packet_basics();
		test_ordering_and_abandon();
		test_config_extremes();
		test_random_traffic();
		test_steady_stream();

		wait_idle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/wjbf_pkg.sv
rtl/wjbf_ram.sv
rtl/watermark_jitter_byte_fifo_top.sv
sim/tb_top.sv
